>>> rtl/core/sha_pkg.sv
package sha_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] hash_t;
  typedef word_t [15:0] block_t;

  // sequencer states of the top level
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DATA,
    ST_PAD,
    ST_EXTRA,
    ST_LEN,
    ST_FINAL,
    ST_OUT
  } sha_state_t;

  // status from the round engine
  typedef struct packed {
    logic       done;
    logic [3:0] blk_idx;
  } core_stat_t;

  localparam int BlockBytes = 64;
  localparam int LenByte    = 56;
  localparam int Rounds     = 64;
  localparam logic [7:0] PadMark = 8'h80;

  localparam hash_t HashInit = '{
    0: 32'h6a09e667, 1: 32'hbb67ae85, 2: 32'h3c6ef372, 3: 32'ha54ff53a,
    4: 32'h510e527f, 5: 32'h9b05688c, 6: 32'h1f83d9ab, 7: 32'h5be0cd19
  };

  localparam word_t RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

>>> rtl/core/sha_in_if.sv
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

>>> rtl/core/sha_out_if.sv
interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        digest_last;

  modport source (output valid, digest_word, digest_last, input ready);
  modport sink (input valid, digest_word, digest_last, output ready);
endinterface

>>> rtl/core/sha_core.sv
module sha_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  sha_pkg::hash_t      hash_in,
  input  sha_pkg::word_t      blk_word,
  output sha_pkg::core_stat_t stat,
  output sha_pkg::hash_t      sum_out
);

  function automatic sha_pkg::word_t rotr(sha_pkg::word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic           busy_r;
  logic           phase_r;
  logic [5:0]     round_r;
  logic           done_r;
  sha_pkg::hash_t v_r;
  sha_pkg::block_t win_r;
  sha_pkg::word_t w_r;
  sha_pkg::word_t hk_r;

  sha_pkg::word_t sched;
  sha_pkg::word_t w_new;
  sha_pkg::word_t t1;
  sha_pkg::word_t t2;
  sha_pkg::word_t ch;
  sha_pkg::word_t maj;

  // message schedule: block words first, then the recurrence over the window
  always_comb begin
    sched = win_r[0]
          + (rotr(win_r[1], 7) ^ rotr(win_r[1], 18) ^ (win_r[1] >> 3))
          + win_r[9]
          + (rotr(win_r[14], 17) ^ rotr(win_r[14], 19) ^ (win_r[14] >> 10));
    w_new = (round_r[5:4] == 2'b00) ? blk_word : sched;
  end

  // round function
  always_comb begin
    ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1  = hk_r + w_r + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25)) + ch;
    t2  = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22)) + maj;
  end

  // round sequencer: each round has a schedule phase, then an update phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
      round_r <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        phase_r <= 1'b0;
        round_r <= '0;
      end else if (busy_r) begin
        phase_r <= ~phase_r;
        if (phase_r) begin
          round_r <= round_r + 6'd1;
          if (round_r == 6'(sha_pkg::Rounds - 1)) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  // working variables and schedule window
  always_ff @(posedge clk) begin
    if (start) begin
      v_r <= hash_in;
    end else if (busy_r && !phase_r) begin
      w_r   <= w_new;
      hk_r  <= v_r[7] + sha_pkg::RoundK[round_r];
      win_r <= {w_new, win_r[15:1]};
    end else if (busy_r && phase_r) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  // chaining add, taken by the top level on done
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      sum_out[i] = hash_in[i] + v_r[i];
    end
  end

  assign stat.done    = done_r;
  assign stat.blk_idx = round_r[3:0];

endmodule

>>> rtl/core/sha256_stream_hasher_unit.sv
// sha-256 over a byte stream
// in_ch: one beat per item, carrying data_byte with has_byte set, and/or
//   end_of_message to close the message (a beat with neither does nothing)
// out_ch: eight beats per message, digest words 0 to 7, digest_last on word 7
// an ordinary byte beat is taken while idle; the beat that fills a 64-byte
//   block starts the round engine, which runs 64 rounds, and in_ch.ready
//   stays low until that compression is done
// on end_of_message: a padding step, then one compression, before the first
//   digest beat is offered; two compressions are needed when fewer than 9
//   bytes are left in the block; an end beat that also fills a block first
//   waits for that block's compression
// no new bytes are taken while a block is compressed, since all blocks go
//   through the shared round engine
// while digest words are waiting, in_ch is not ready; a stalled out_ch simply
//   holds the current word until taken
// reset (rst_n low, synchronous) loads the initial hash values, clears the
//   byte count and returns to idle; hashing restarts from the initial values
//   after every digest
module sha256_stream_hasher_unit (
  input  logic      clk,
  input  logic      rst_n,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);

  sha_pkg::sha_state_t state_r, state_nxt;
  sha_pkg::hash_t      hash_r, hash_nxt;
  sha_pkg::block_t     block_r, block_nxt;
  logic [63:0]         count_r, count_nxt;
  logic                eom_r, eom_nxt;
  logic [2:0]          k_r, k_nxt;

  logic                core_start;
  sha_pkg::core_stat_t core_stat;
  sha_pkg::hash_t      core_sum;
  logic [5:0]          idx;
  logic [63:0]         len_bits;
  logic [5:0]          pos;
  logic                in_acc;

  sha_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (core_start),
    .hash_in  (hash_r),
    .blk_word (block_r[core_stat.blk_idx]),
    .stat     (core_stat),
    .sum_out  (core_sum)
  );

  assign idx      = count_r[5:0];
  assign len_bits = {count_r[60:0], 3'b000};
  assign in_acc   = in_ch.valid && in_ch.ready;

  // handshake outputs
  assign in_ch.ready        = (state_r == sha_pkg::ST_IDLE);
  assign out_ch.valid       = (state_r == sha_pkg::ST_OUT);
  assign out_ch.digest_word = hash_r[k_r];
  assign out_ch.digest_last = (k_r == 3'd7);

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    hash_nxt   = hash_r;
    block_nxt  = block_r;
    count_nxt  = count_r;
    eom_nxt    = eom_r;
    k_nxt      = k_r;
    core_start = 1'b0;
    pos        = '0;
    case (state_r)
      sha_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.has_byte) begin
            block_nxt[idx[5:2]][{~idx[1:0], 3'b000} +: 8] = in_ch.data_byte;
            count_nxt = count_r + 64'd1;
          end
          if (in_ch.has_byte && idx == 6'(sha_pkg::BlockBytes - 1)) begin
            core_start = 1'b1;
            eom_nxt    = in_ch.end_of_message;
            state_nxt  = sha_pkg::ST_DATA;
          end else if (in_ch.end_of_message) begin
            state_nxt = sha_pkg::ST_PAD;
          end
        end
      end
      sha_pkg::ST_DATA: begin
        if (core_stat.done) begin
          hash_nxt  = core_sum;
          state_nxt = eom_r ? sha_pkg::ST_PAD : sha_pkg::ST_IDLE;
        end
      end
      sha_pkg::ST_PAD: begin
        // mark byte after the message, zeros behind it
        for (int j = 0; j < 16; j++) begin
          for (int b = 0; b < 4; b++) begin
            pos = 6'(4 * j + b);
            if (pos == idx) begin
              block_nxt[j][8 * (3 - b) +: 8] = sha_pkg::PadMark;
            end else if (pos > idx) begin
              block_nxt[j][8 * (3 - b) +: 8] = 8'h00;
            end
          end
        end
        core_start = 1'b1;
        if (idx < 6'(sha_pkg::LenByte)) begin
          block_nxt[14] = len_bits[63:32];
          block_nxt[15] = len_bits[31:0];
          state_nxt     = sha_pkg::ST_FINAL;
        end else begin
          state_nxt = sha_pkg::ST_EXTRA;
        end
      end
      sha_pkg::ST_EXTRA: begin
        if (core_stat.done) begin
          hash_nxt  = core_sum;
          state_nxt = sha_pkg::ST_LEN;
        end
      end
      sha_pkg::ST_LEN: begin
        // extra block: all zeros and the bit length
        block_nxt     = '0;
        block_nxt[14] = len_bits[63:32];
        block_nxt[15] = len_bits[31:0];
        core_start    = 1'b1;
        state_nxt     = sha_pkg::ST_FINAL;
      end
      sha_pkg::ST_FINAL: begin
        if (core_stat.done) begin
          hash_nxt  = core_sum;
          k_nxt     = '0;
          state_nxt = sha_pkg::ST_OUT;
        end
      end
      sha_pkg::ST_OUT: begin
        if (out_ch.ready) begin
          k_nxt = k_r + 3'd1;
          if (k_r == 3'd7) begin
            hash_nxt  = sha_pkg::HashInit;
            count_nxt = '0;
            state_nxt = sha_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = sha_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha_pkg::ST_IDLE;
      hash_r  <= sha_pkg::HashInit;
      count_r <= '0;
      eom_r   <= 1'b0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      hash_r  <= hash_nxt;
      count_r <= count_nxt;
      eom_r   <= eom_nxt;
      k_r     <= k_nxt;
    end
  end

  // block buffer
  always_ff @(posedge clk) begin
    block_r <= block_nxt;
  end

endmodule
